@@ src/ame_pkg.sv @@
// Package: constants, opcodes and types for the accumulator machine execute block
`timescale 1ns / 1ps
package ame_pkg;
  localparam int unsigned MemWords = 100;
  localparam int unsigned AddrW = 7;
  localparam int unsigned DataW = 32;
  localparam int unsigned FlagW = 5;
  localparam logic signed [DataW-1:0] ReadMax = 32'sd65535;
  localparam logic signed [DataW-1:0] ReadMin = -32'sd65535;

  localparam int unsigned FlagOvf = 0;
  localparam int unsigned FlagZdiv = 1;
  localparam int unsigned FlagOob = 2;

  typedef enum logic [6:0] {
    OpRead = 7'd10, OpWrite = 7'd11, OpLoad = 7'd20, OpStore = 7'd21,
    OpAdd = 7'd30, OpSub = 7'd31, OpDiv = 7'd32, OpMul = 7'd33,
    OpJmp = 7'd40, OpJneg = 7'd41, OpJz = 7'd42, OpHalt = 7'd43,
    OpNot = 7'd51, OpAnd = 7'd52, OpOr = 7'd53, OpXor = 7'd54,
    OpJpos = 7'd55, OpJovf = 7'd56, OpJnoovf = 7'd57, OpJeven = 7'd58,
    OpJodd = 7'd59, OpShl1 = 7'd60, OpShr1 = 7'd61, OpRol1 = 7'd62,
    OpRor1 = 7'd63, OpNegCopy = 7'd64, OpAddIdx = 7'd65, OpSubIdx = 7'd66,
    OpShl = 7'd67, OpShr = 7'd68, OpRol = 7'd69, OpRor = 7'd70,
    OpMovIdxTo = 7'd71, OpMovIdxFrom = 7'd72, OpMovIndTo = 7'd73,
    OpMovIndFrom = 7'd74, OpAddInd = 7'd75, OpSubInd = 7'd76
  } opcode_e;

  typedef enum logic [3:0] {
    StIdle, StClear, StRdOp, StWaitOp, StRdIdx, StWaitIdx, StRdPtr, StWaitPtr,
    StExec, StDiv, StMul, StOut
  } state_e;

  function automatic logic idx_ok(input logic [DataW-1:0] v);
    idx_ok = (v >= DataW'(1)) && (v < DataW'(MemWords));
  endfunction
endpackage

@@ src/accumulator_machine_execute.sv @@
// Top level: accumulator machine execute block
`timescale 1ns / 1ps
// One request at a time. After reset the block sweeps the 100-word memory to
// zero before taking any request. A preload, a halt or an out-of-range operand
// goes from the operand read straight to the result; most instructions pass
// through an execute step, multiply through its own step (three 16x16 partial
// products). Indexed and indirect forms take longer, because they make
// dependent reads of the single-port word memory; a rejected index ends them
// sooner. Divide runs the iterative divider (one quotient bit per cycle), and
// ends early on a zero divisor. The next request can be taken in the same
// cycle as the result appears. The result sits in an output register, and
// the next request is taken while it waits.
module accumulator_machine_execute
  import ame_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             preload_i,
  input  logic [6:0]       opcode_i,
  input  logic [6:0]       operand_i,
  input  logic [31:0]      data_in_i,
  output logic             res_valid_o,
  input  logic             res_stall_i,
  output logic             out_valid_o,
  output logic [31:0]      out_value_o,
  output logic [31:0]      accumulator_o,
  output logic [6:0]       counter_o,
  output logic [4:0]       flag_bits_o,
  output logic             halted_o
);
  state_e state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic pre_q, pre_d;
  logic [6:0] opc_q, opc_d;
  logic [AddrW-1:0] op_q, op_d;
  logic [DataW-1:0] din_q, din_d;
  logic [DataW-1:0] m_q, m_d, x_q, x_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [6:0] cnt_q, cnt_d;
  logic [FlagW-1:0] flg_q, flg_d;
  logic halt_q, halt_d;
  logic rv_q, rv_d, ov_q, ov_d;
  logic [DataW-1:0] oval_q, oval_d;
  logic [DataW-1:0] pll_q, plh_q, phl_q, pll_d, plh_d, phl_d;

  logic             we;
  logic [AddrW-1:0] addr;
  logic [DataW-1:0] wdata, rdata;
  logic             div_start, div_done;
  logic [DataW-1:0] quot;
  logic             is_idx, is_ind;
  logic [DataW-1:0] sa;
  logic [4:0]       sh;

  ame_ram #(.Width(DataW), .Depth(MemWords)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  ame_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(acc_q), .divisor_i(rdata),
    .done_o(div_done), .quot_o(quot)
  );

  assign in_stall_o = (state_q != StIdle);
  assign is_idx = (opc_q == OpAddIdx) || (opc_q == OpSubIdx) ||
                  (opc_q == OpMovIdxTo) || (opc_q == OpMovIdxFrom);
  assign is_ind = (opc_q == OpMovIndTo) || (opc_q == OpMovIndFrom) ||
                  (opc_q == OpAddInd) || (opc_q == OpSubInd);
  assign sh = acc_q[4:0];

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    pre_d = pre_q;
    opc_d = opc_q;
    op_d = op_q;
    din_d = din_q;
    m_d = m_q;
    x_d = x_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    flg_d = flg_q;
    halt_d = halt_q;
    rv_d = rv_q && res_stall_i;
    ov_d = ov_q;
    oval_d = oval_q;
    pll_d = rdata[15:0] * acc_q[15:0];
    plh_d = rdata[15:0] * acc_q[31:16];
    phl_d = rdata[31:16] * acc_q[15:0];
    we = 1'b0;
    addr = op_q;
    wdata = '0;
    div_start = 1'b0;
    sa = '0;
    unique case (state_q)
      StClear: begin
        we = 1'b1;
        addr = clr_q;
        wdata = '0;
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MemWords - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          pre_d = preload_i;
          opc_d = opcode_i;
          op_d = operand_i;
          din_d = data_in_i;
          state_d = StRdOp;
        end
      end
      StRdOp: begin
        if (!pre_q && opc_q == OpHalt) begin
          halt_d = 1'b1;
          state_d = StOut;
        end else if (op_q >= AddrW'(MemWords)) begin
          flg_d[FlagOob] = 1'b1;
          state_d = StOut;
        end else if (pre_q) begin
          we = 1'b1;
          wdata = din_q;
          state_d = StOut;
        end else begin
          state_d = StWaitOp;
        end
      end
      StWaitOp: begin
        m_d = rdata;
        if (is_idx || is_ind) begin
          if (!idx_ok(acc_q)) begin
            flg_d[FlagOob] = 1'b1;
            state_d = StOut;
          end else begin
            state_d = StRdIdx;
          end
        end else if (opc_q == OpDiv) begin
          if (rdata == '0) begin
            flg_d[FlagZdiv] = 1'b1;
            state_d = StOut;
          end else begin
            state_d = StDiv;
            div_start = 1'b1;
          end
        end else if (opc_q == OpMul) begin
          state_d = StMul;
        end else begin
          state_d = StExec;
        end
      end
      StRdIdx: begin
        addr = acc_q[AddrW-1:0];
        state_d = StWaitIdx;
      end
      StWaitIdx: begin
        x_d = rdata;
        if (is_ind) begin
          if (!idx_ok(rdata)) begin
            flg_d[FlagOob] = 1'b1;
            state_d = StOut;
          end else begin
            state_d = StRdPtr;
          end
        end else begin
          state_d = StExec;
        end
      end
      StRdPtr: begin
        addr = x_q[AddrW-1:0];
        state_d = StWaitPtr;
      end
      StWaitPtr: begin
        state_d = StExec;
        if (opc_q == OpMovIndTo) begin
          x_d = x_q;
        end else begin
          x_d = rdata;
        end
      end
      StDiv: begin
        if (div_done) begin
          acc_d = quot;
          state_d = StOut;
        end
      end
      StMul: begin
        acc_d = pll_q + {plh_q[15:0] + phl_q[15:0], 16'h0000};
        state_d = StOut;
      end
      StExec: begin
        state_d = StOut;
        sa = acc_q;
        unique case (opc_q)
          OpRead: begin
            if ($signed(din_q) >= ReadMin && $signed(din_q) <= ReadMax) begin
              we = 1'b1;
              wdata = din_q;
            end else begin
              flg_d[FlagOvf] = 1'b1;
            end
          end
          OpWrite: begin
            ov_d = 1'b1;
            oval_d = m_q;
          end
          OpLoad, OpNegCopy: acc_d = m_q;
          OpStore: begin
            we = 1'b1;
            wdata = acc_q;
          end
          OpAdd: acc_d = acc_q + m_q;
          OpSub: acc_d = acc_q - m_q;
          OpJmp: cnt_d = op_q;
          OpJneg: if (sa[DataW-1]) cnt_d = op_q;
          OpJz: if (acc_q == '0) cnt_d = op_q;
          OpNot: begin
            we = 1'b1;
            wdata = ~acc_q;
          end
          OpAnd: acc_d = acc_q & m_q;
          OpOr: acc_d = acc_q | m_q;
          OpXor: acc_d = acc_q ^ m_q;
          OpJpos: if (!sa[DataW-1] && sa != '0) cnt_d = op_q;
          OpJovf: if (flg_q[FlagOvf]) cnt_d = op_q;
          OpJnoovf: if (!flg_q[FlagOvf]) cnt_d = op_q;
          OpJeven: if (!acc_q[0]) cnt_d = op_q;
          OpJodd: if (acc_q[0]) cnt_d = op_q;
          OpShl1: acc_d = {m_q[DataW-2:0], 1'b0};
          OpShr1: acc_d = {m_q[DataW-1], m_q[DataW-1:1]};
          OpRol1: acc_d = {m_q[DataW-2:0], m_q[DataW-1]};
          OpRor1: acc_d = {m_q[0], m_q[DataW-1:1]};
          OpShl: acc_d = m_q << sh;
          OpShr: acc_d = DataW'($signed(m_q) >>> sh);
          OpRol: acc_d = (m_q << sh) | ((sh == '0) ? '0 : (m_q >> (6'd32 - {1'b0, sh})));
          OpRor: acc_d = (m_q >> sh) | ((sh == '0) ? '0 : (m_q << (6'd32 - {1'b0, sh})));
          OpAddIdx, OpAddInd: acc_d = m_q + x_q;
          OpSubIdx, OpSubInd: acc_d = m_q - x_q;
          OpMovIdxTo: begin
            we = 1'b1;
            addr = acc_q[AddrW-1:0];
            wdata = m_q;
          end
          OpMovIndTo: begin
            we = 1'b1;
            addr = x_q[AddrW-1:0];
            wdata = m_q;
          end
          OpMovIdxFrom, OpMovIndFrom: begin
            we = 1'b1;
            wdata = x_q;
          end
          default: ;
        endcase
      end
      StOut: begin
        if (!rv_q || !res_stall_i) begin
          rv_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StIdle && in_valid_i) begin
      ov_d = 1'b0;
      oval_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      acc_q <= '0;
      cnt_q <= '0;
      flg_q <= '0;
      halt_q <= 1'b0;
      rv_q <= 1'b0;
      ov_q <= 1'b0;
      oval_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      flg_q <= flg_d;
      halt_q <= halt_d;
      rv_q <= rv_d;
      ov_q <= ov_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q <= pre_d;
    opc_q <= opc_d;
    op_q <= op_d;
    din_q <= din_d;
    m_q <= m_d;
    x_q <= x_d;
    pll_q <= pll_d;
    plh_q <= plh_d;
    phl_q <= phl_d;
  end

  // Outputs hold the state after the last request; they change only on a new result.
  logic [DataW-1:0] acc_out_q;
  logic [6:0]       cnt_out_q;
  logic [FlagW-1:0] flg_out_q;
  logic             halt_out_q;

  always_ff @(posedge clk_i) begin
    if (state_q == StOut && (!rv_q || !res_stall_i)) begin
      acc_out_q <= acc_q;
      cnt_out_q <= cnt_q;
      flg_out_q <= flg_q;
      halt_out_q <= halt_q;
    end
  end

  logic ov_out_q;
  logic [DataW-1:0] oval_out_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StOut && (!rv_q || !res_stall_i)) begin
      ov_out_q <= ov_q;
      oval_out_q <= oval_q;
    end
  end

  assign res_valid_o = rv_q;
  assign out_valid_o = ov_out_q;
  assign out_value_o = oval_out_q;
  assign accumulator_o = acc_out_q;
  assign counter_o = cnt_out_q;
  assign flag_bits_o = flg_out_q;
  assign halted_o = halt_out_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("request taken while busy");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt bit dropped");
  a_flags_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((flg_q & ~flg_d) == '0)) else $error("flag cleared");
  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !rv_q) else $error("result during clear");
`endif
endmodule

@@ src/ame_ram.sv @@
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module ame_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 100
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ src/ame_div.sv @@
// Iterative signed divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ame_div
  import ame_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [DataW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(DataW + 1);
  logic [DataW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             neg_q, neg_d, busy_q, busy_d;
  logic [DataW:0]   trial;
  logic [DataW:0]   shifted;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    busy_d = busy_q;
    shifted = {rem_q, quo_q[DataW-1]};
    trial = shifted - {1'b0, dvs_q};
    done_o = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i[DataW-1] ? (~dividend_i + DataW'(1)) : dividend_i;
      dvs_d = divisor_i[DataW-1] ? (~divisor_i + DataW'(1)) : divisor_i;
      neg_d = dividend_i[DataW-1] ^ divisor_i[DataW-1];
      cnt_d = CntW'(DataW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (!trial[DataW]) begin
          rem_d = trial[DataW-1:0];
          quo_d = {quo_q[DataW-2:0], 1'b1};
        end else begin
          rem_d = shifted[DataW-1:0];
          quo_d = {quo_q[DataW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  assign quot_o = neg_q ? (~quo_q + DataW'(1)) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end
endmodule
